// ===== hdl/aevs_pkg.sv =====
// Package for the adaptive EMA vector smoother.
// Holds action codes, controller/datapath command and status types and
// fixed-point constants. Depends on nothing.
package aevs_pkg;

  localparam int SAMPLE_W = 32;
  localparam int ALPHA_W  = 17;
  localparam int NUM_CH   = 3;
  localparam int NUM_AXES = 3;
  localparam int AXIS_W   = 2;
  localparam int DIST_W   = 34;

  localparam logic [ALPHA_W-1:0] ONE_Q16     = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd32768;
  localparam logic [DIST_W-1:0]  THR_LINEAR  = 34'd25600;
  localparam logic [DIST_W-1:0]  THR_ROT     = 34'd512;
  // ceil(2^26 / 25): floor(x / 25) = (x * RECIP_25) >> 26 for x below 2^21.
  localparam logic [21:0]        RECIP_25    = 22'd2684355;
  localparam logic [50:0]        ROUND_HALF  = 51'd32768;

  localparam logic [AXIS_W-1:0] GAZE_LAST_AXIS = 2'd1;
  localparam logic [AXIS_W-1:0] VEC_LAST_AXIS  = 2'd2;

  localparam logic CFG_ALPHA    = 1'b0;
  localparam logic CFG_ADAPTIVE = 1'b1;

  typedef enum logic [1:0] {
    ACT_GAZE     = 2'd0,
    ACT_POSITION = 2'd1,
    ACT_ROTATION = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_t;

  typedef struct packed {
    logic              load;
    logic              clear;
    logic              pass;
    logic              accum;
    logic              norm;
    logic              scale;
    logic              weight;
    logic              diff;
    logic              mul;
    logic              add;
    logic              out_load;
    logic [AXIS_W-1:0] axis;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    seen;
    logic    adaptive;
    logic    out_free;
  } stat_t;

endpackage

// ===== hdl/aevs_ifs.sv =====
// Valid/ready channel interfaces for samples and smoothed results.
// Depends on aevs_pkg.
interface aevs_sample_if;
  import aevs_pkg::*;
  logic               valid;
  logic               ready;
  action_t            action;
  logic signed [31:0] comp_a;
  logic signed [31:0] comp_b;
  logic signed [31:0] comp_c;
  modport source (output valid, action, comp_a, comp_b, comp_c, input ready);
  modport sink (input valid, action, comp_a, comp_b, comp_c, output ready);
endinterface

interface aevs_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_a;
  logic signed [31:0] out_b;
  logic signed [31:0] out_c;
  logic               passed_through;
  modport source (output valid, out_a, out_b, out_c, passed_through, input ready);
  modport sink (input valid, out_a, out_b, out_c, passed_through, output ready);
endinterface

// ===== hdl/adaptive_ema_vector_smoother.sv =====
// Adaptive EMA vector smoother top level. A clear or first sample goes from decide
// to the result stage; others run weight, then diff, multiply and add per axis
// (2 axes for gaze, 3 otherwise), after a distance pass over the axes and norm
// and scale in adaptive mode. A new sample is taken in the cycle after its result
// is registered. The lerp multiplier is shared across axes. Synchronous active-high
// reset zeroes every store and seen flag and loads alpha 0.5 with adaptive mode off.
module adaptive_ema_vector_smoother (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [aevs_pkg::ALPHA_W-1:0] cfg_data,
  aevs_sample_if.sink                  sample,
  aevs_result_if.source                result
);
  import aevs_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign sample.ready = in_ready;

  aevs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  aevs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .result    (result),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== hdl/aevs_ctrl.sv =====
// Sequencing state machine for the smoother.
// Issues datapath commands and steps through the axes. Depends on aevs_pkg.
module aevs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  aevs_pkg::stat_t stat,
  output aevs_pkg::cmd_t  cmd
);
  import aevs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_DIST, S_NORM, S_SCALE, S_WEIGHT, S_DIFF, S_MUL, S_ADD, S_DONE
  } state_t;

  state_t            state;
  logic [AXIS_W-1:0] axis;
  logic              last_axis;

  assign last_axis = (axis == ((stat.action == ACT_GAZE) ? GAZE_LAST_AXIS : VEC_LAST_AXIS));
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          axis <= '0;
          if (in_valid) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (stat.action == ACT_CLEAR || !stat.seen) state <= S_DONE;
          else if (stat.adaptive) state <= S_DIST;
          else state <= S_WEIGHT;
        end
        S_DIST: begin
          if (last_axis) begin
            axis  <= '0;
            state <= S_NORM;
          end else begin
            axis <= axis + 1'b1;
          end
        end
        S_NORM:   state <= S_SCALE;
        S_SCALE:  state <= S_WEIGHT;
        S_WEIGHT: state <= S_DIFF;
        S_DIFF:   state <= S_MUL;
        S_MUL:    state <= S_ADD;
        S_ADD: begin
          if (last_axis) begin
            state <= S_DONE;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_DIFF;
          end
        end
        S_DONE: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.axis     = axis;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.clear    = (state == S_DECIDE) && (stat.action == ACT_CLEAR);
    cmd.pass     = (state == S_DECIDE) && (stat.action != ACT_CLEAR) && !stat.seen;
    cmd.accum    = (state == S_DIST);
    cmd.norm     = (state == S_NORM);
    cmd.scale    = (state == S_SCALE);
    cmd.weight   = (state == S_WEIGHT);
    cmd.diff     = (state == S_DIFF);
    cmd.mul      = (state == S_MUL);
    cmd.add      = (state == S_ADD);
    cmd.out_load = (state == S_DONE) && stat.out_free;
  end

endmodule

// ===== hdl/aevs_datapath.sv =====
// Datapath of the smoother: channel stores, configuration registers,
// distance accumulator, adaptive weight and the shared lerp multiplier.
// Depends on aevs_pkg and aevs_ifs.
module aevs_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic                            cfg_index,
  input  logic [aevs_pkg::ALPHA_W-1:0]    cfg_data,
  aevs_sample_if.sink                     sample,
  aevs_result_if.source                   result,
  input  aevs_pkg::cmd_t                  cmd,
  output aevs_pkg::stat_t                 stat
);
  import aevs_pkg::*;

  logic [ALPHA_W-1:0]  alpha;
  logic                adaptive_enable;
  logic [ALPHA_W-1:0]  alpha_clamped;

  logic [SAMPLE_W-1:0] store [NUM_CH][NUM_AXES];
  logic [NUM_CH-1:0]   seen;

  action_t             action;
  logic [SAMPLE_W-1:0] comp [NUM_AXES];
  logic [SAMPLE_W-1:0] res [NUM_AXES];
  logic                pass_flag;

  logic [DIST_W-1:0]   distance;
  logic [ALPHA_W-1:0]  norm;
  logic [33:0]         scale_prod;
  logic [ALPHA_W-1:0]  weight;
  logic signed [32:0]  diff;
  logic signed [50:0]  lerp_prod;

  logic [1:0]          chan;
  logic [SAMPLE_W-1:0] cur_store;
  logic [SAMPLE_W-1:0] cur_in;
  logic signed [32:0]  cur_diff;
  logic [32:0]         cur_abs;
  logic [20:0]         lin_x;
  logic [42:0]         lin_prod;
  logic [ALPHA_W-1:0]  norm_next;
  logic [50:0]         rounded;
  logic [SAMPLE_W-1:0] lerp_out;

  assign chan          = action;
  assign alpha_clamped = (alpha > ONE_Q16) ? ONE_Q16 : alpha;
  assign cur_store     = store[chan][cmd.axis];
  assign cur_in        = comp[cmd.axis];
  assign cur_diff      = $signed({cur_in[SAMPLE_W-1], cur_in})
                       - $signed({cur_store[SAMPLE_W-1], cur_store});
  assign cur_abs       = cur_diff[32] ? 33'(-cur_diff) : 33'(cur_diff);
  assign lin_x         = {distance[14:0], 6'b0};
  assign lin_prod      = 43'(lin_x) * 43'(RECIP_25);
  assign rounded       = 51'(lerp_prod) + ROUND_HALF;
  assign lerp_out      = store[chan][cmd.axis] + rounded[47:16];

  always_comb begin
    if (action == ACT_ROTATION) begin
      norm_next = (distance >= THR_ROT) ? ONE_Q16 : {1'b0, distance[8:0], 7'b0};
    end else begin
      norm_next = (distance >= THR_LINEAR) ? ONE_Q16 : lin_prod[42:26];
    end
  end

  assign stat.action   = action;
  assign stat.seen     = (action == ACT_CLEAR) ? 1'b0 : seen[chan];
  assign stat.adaptive = adaptive_enable;
  assign stat.out_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha           <= ALPHA_RESET;
      adaptive_enable <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == CFG_ALPHA) alpha <= cfg_data;
      else if (cfg_index == CFG_ADAPTIVE) adaptive_enable <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        for (int i = 0; i < NUM_AXES; i++) store[c][i] <= '0;
      end
    end else if (cmd.clear) begin
      seen <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        for (int i = 0; i < NUM_AXES; i++) store[c][i] <= '0;
      end
    end else if (cmd.pass) begin
      seen[chan] <= 1'b1;
      store[chan][0] <= comp[0];
      store[chan][1] <= comp[1];
      if (action != ACT_GAZE) store[chan][2] <= comp[2];
    end else if (cmd.add) begin
      store[chan][cmd.axis] <= lerp_out;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action    <= sample.action;
      comp[0]   <= sample.comp_a;
      comp[1]   <= sample.comp_b;
      comp[2]   <= sample.comp_c;
      for (int i = 0; i < NUM_AXES; i++) res[i] <= '0;
      pass_flag <= 1'b0;
      distance  <= '0;
    end
    if (cmd.pass) begin
      pass_flag <= 1'b1;
      res[0]    <= comp[0];
      res[1]    <= comp[1];
      if (action != ACT_GAZE) res[2] <= comp[2];
    end
    if (cmd.accum)  distance   <= distance + DIST_W'(cur_abs);
    if (cmd.norm)   norm       <= norm_next;
    if (cmd.scale)  scale_prod <= 34'(alpha_clamped) * 34'(norm);
    if (cmd.weight) begin
      weight <= adaptive_enable ? (alpha_clamped - scale_prod[33:17]) : alpha_clamped;
    end
    if (cmd.diff)   diff       <= cur_diff;
    if (cmd.mul)    lerp_prod  <= 51'(diff) * 51'($signed({1'b0, weight}));
    if (cmd.add)    res[cmd.axis] <= lerp_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.out_a          <= res[0];
      result.out_b          <= res[1];
      result.out_c          <= res[2];
      result.passed_through <= pass_flag;
    end
  end

endmodule
